### hdl/brd_pkg.sv
// Package for the byte ring deque: command codes, field widths and result word layout.
// Used by brd_ram, byte_ring_deque_core and brd_chk; depends on nothing.
package brd_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int OCC_W  = 5;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_PUSH_FRONT = 2'd0;
  localparam cmd_t CMD_PUSH_BACK  = 2'd1;
  localparam cmd_t CMD_POP_FRONT  = 2'd2;
  localparam cmd_t CMD_POP_BACK   = 2'd3;

  // packed lowest field last: pop_byte sits in bits 7:0
  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic              now_empty;
    logic              now_full;
    logic              accepted;
    logic [BYTE_W-1:0] pop_byte;
  } result_t;

endpackage

### hdl/brd_ram.sv
// Slot store of the byte ring deque: one write port, one read port, registered read data.
// Depends on brd_pkg for the byte width.
module brd_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [brd_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [brd_pkg::BYTE_W-1:0] rdata
);

  logic [brd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [brd_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/byte_ring_deque_core.sv
// Top level of the byte ring deque: pointers, count, sequencing and output register.
// Depends on brd_pkg and brd_ram.
//
//  channel  dir  tdata fields (low bit up)                                    width
//  in_      in   cmd[1:0] push_byte[9:2] zero[15:10]                           16
//  out_     out  pop_byte[7:0] accepted[8] now_full[9] now_empty[10] occ[15:11] 16
//
// A push, and a pop refused on empty, are answered straight from the output register; an
// accepted pop passes through ST_READ first, as the slot store's read data is registered.
// in_tready is low while a pop read is in flight and while an untaken result blocks
// the output register.
// rst_n clears pointers, count and state; slot contents are not cleared.
module byte_ring_deque_core #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [brd_pkg::IN_W-1:0]  in_tdata,   // cmd[1:0], push_byte[9:2]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [brd_pkg::OUT_W-1:0] out_tdata   // pop_byte, accepted, now_full, now_empty, occupancy
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                       state_r, state_nxt;
  logic [PW-1:0]              head_r, head_nxt;
  logic [PW-1:0]              tail_r, tail_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  brd_pkg::result_t           out_r, out_nxt;

  brd_pkg::cmd_t              cmd;
  logic [brd_pkg::BYTE_W-1:0] push_byte;
  logic                       acc, is_full, cnt_zero, ok, pop_go;
  logic [PW-1:0]              head_up, head_dn, tail_up, tail_dn;
  logic                       we, re;
  logic [PW-1:0]              waddr, raddr;
  logic [brd_pkg::BYTE_W-1:0] rdata;

  assign cmd       = in_tdata[brd_pkg::CMD_W-1:0];
  assign push_byte = in_tdata[brd_pkg::CMD_W +: brd_pkg::BYTE_W];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign is_full   = (cnt_r == CW'(DEPTH));
  assign cnt_zero  = (cnt_r == '0);

  assign head_up = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dn = (head_r == '0) ? PW'(DEPTH - 1) : head_r - 1'b1;
  assign tail_up = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dn = (tail_r == '0) ? PW'(DEPTH - 1) : tail_r - 1'b1;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = tail_r;
    raddr    = head_r;
    ok       = 1'b0;
    unique case (cmd)
      brd_pkg::CMD_PUSH_FRONT: begin
        ok    = !is_full;
        waddr = head_dn;
        if (acc && ok) begin
          we       = 1'b1;
          head_nxt = head_dn;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      brd_pkg::CMD_PUSH_BACK: begin
        ok    = !is_full;
        waddr = tail_r;
        if (acc && ok) begin
          we       = 1'b1;
          tail_nxt = tail_up;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      brd_pkg::CMD_POP_FRONT: begin
        ok    = !cnt_zero;
        raddr = head_r;
        if (acc && ok) begin
          re       = 1'b1;
          head_nxt = head_up;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      brd_pkg::CMD_POP_BACK: begin
        ok    = !cnt_zero;
        raddr = tail_dn;
        if (acc && ok) begin
          re       = 1'b1;
          tail_nxt = tail_dn;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pop_go = acc && ok && cmd[1];

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    priority if (state_r == ST_READ) begin
      state_nxt         = ST_IDLE;
      out_nxt.pop_byte  = rdata;
      out_nxt.accepted  = 1'b1;
      out_nxt.now_full  = is_full;
      out_nxt.now_empty = cnt_zero;
      out_nxt.occupancy = brd_pkg::OCC_W'(cnt_r);
      out_valid_nxt     = 1'b1;
    end else if (pop_go) begin
      state_nxt = ST_READ;
    end else if (acc) begin
      out_nxt.pop_byte  = '0;
      out_nxt.accepted  = ok;
      out_nxt.now_full  = (cnt_nxt == CW'(DEPTH));
      out_nxt.now_empty = (cnt_nxt == '0);
      out_nxt.occupancy = brd_pkg::OCC_W'(cnt_nxt);
      out_valid_nxt     = 1'b1;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  brd_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

### hdl/brd_chk.sv
// Port-level checker for byte_ring_deque_core, attached by the bind below.
// Depends on brd_pkg for the word layout.
module brd_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [brd_pkg::IN_W-1:0]  in_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [brd_pkg::OUT_W-1:0] out_tdata
);

  brd_pkg::result_t res;
  assign res = out_tdata;

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a push answers in the next cycle with a zero byte
  a_push_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tdata[1]) |=> (out_tvalid && res.pop_byte == '0))
    else $error("push result missing or carries a byte");

  // a refused command never carries a byte
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.accepted) |-> (res.pop_byte == '0))
    else $error("refused command returned a byte");

  // empty and full exclude each other, empty means zero held
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.now_empty) |-> (!res.now_full && res.occupancy == '0))
    else $error("inconsistent empty flag");

endmodule

bind byte_ring_deque_core brd_chk u_brd_chk (.*);
